>>> rtl/multi_channel_long_interval_timer_core_macros.svh
// Assertion macros used by the checker module mclt_checker.
`ifndef MULTI_CHANNEL_LONG_INTERVAL_TIMER_CORE_MACROS_SVH
`define MULTI_CHANNEL_LONG_INTERVAL_TIMER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MCLT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define MCLT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/mclt_pkg.sv
package mclt_pkg;

    localparam int MODE_W    = 2;
    localparam int CHAN_W    = 3;
    localparam int DUR_W     = 32;
    localparam int MASK_W    = 5;
    localparam int MAX_CHANS = 8;
    localparam int CYCLES_W  = 8;
    localparam int CHUNK_W   = 17;
    localparam int CFG_IDX_W = 2;
    localparam int TICK_SHIFT = 8;

    localparam logic [CYCLES_W-1:0] CYCLES_RESET = 8'd16;
    localparam logic [CHUNK_W-1:0]  CHUNK_RESET  = 17'd65536;

    localparam logic [CFG_IDX_W-1:0] CFG_CYCLES    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHUNK = 2'd1;

    typedef enum logic [MODE_W-1:0] {
        MODE_TICK        = 2'd0,
        MODE_START       = 2'd1,
        MODE_STOP        = 2'd2,
        MODE_STOP_NOTIFY = 2'd3
    } mode_t;

    // per-channel command, already qualified by the transfer
    typedef struct packed {
        logic tick;
        logic start;
        logic stop;
        logic notify;
    } chan_cmd_t;

endpackage

>>> rtl/mclt_chan.sv
module mclt_chan #(
    parameter int PERIOD_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mclt_pkg::chan_cmd_t                 cmd,
    input  logic [mclt_pkg::DUR_W-1:0]          duration_usec,
    input  logic [mclt_pkg::CYCLES_W-1:0]       cycles_per_usec,
    input  logic [mclt_pkg::CHUNK_W-1:0]        max_chunk_usec,
    output logic                                running,
    output logic                                expired
);

    localparam int PROD_W = mclt_pkg::CHUNK_W + mclt_pkg::CYCLES_W;
    localparam int PAD_W  = mclt_pkg::DUR_W - mclt_pkg::CHUNK_W;

    logic [mclt_pkg::DUR_W-1:0]   remaining_reg, remaining_next;
    logic [PERIOD_WIDTH-1:0]      period_reg, period_next;
    logic [PERIOD_WIDTH-1:0]      count_reg, count_next;
    logic                         run_reg, run_next;

    logic [mclt_pkg::DUR_W-1:0]   chunk_wide;
    logic [mclt_pkg::CHUNK_W-1:0] seg;
    logic [mclt_pkg::CHUNK_W-1:0] mult_in;
    logic [PROD_W-1:0]            prod;
    logic [PERIOD_WIDTH-1:0]      new_period;

    assign chunk_wide = {{PAD_W{1'b0}}, max_chunk_usec};
    assign seg = (duration_usec > chunk_wide) ? max_chunk_usec
                                              : duration_usec[mclt_pkg::CHUNK_W-1:0];

    // one multiplier: start uses the first segment, a period end the remainder
    // (a remainder below the segment limit always fits the segment width)
    assign mult_in    = cmd.start ? seg : remaining_reg[mclt_pkg::CHUNK_W-1:0];
    assign prod       = PROD_W'(mult_in) * PROD_W'(cycles_per_usec);
    assign new_period = PERIOD_WIDTH'(prod >> mclt_pkg::TICK_SHIFT);

    always_comb
    begin
        remaining_next = remaining_reg;
        period_next    = period_reg;
        count_next     = count_reg;
        run_next       = run_reg;
        expired        = 1'b0;
        priority if (cmd.start)
        begin
            remaining_next = duration_usec - {{PAD_W{1'b0}}, seg};
            period_next    = new_period;
            count_next     = '0;
            run_next       = 1'b1;
        end
        else if (cmd.stop)
        begin
            run_next = 1'b0;
            expired  = cmd.notify;
        end
        else if (cmd.tick && run_reg)
        begin
            if (count_reg != period_reg)
            begin
                count_next = count_reg + PERIOD_WIDTH'(1);
            end
            else
            begin
                count_next = '0;
                priority if (remaining_reg == '0)
                begin
                    run_next = 1'b0;
                    expired  = 1'b1;
                end
                else if (remaining_reg < chunk_wide)
                begin
                    period_next    = new_period;
                    remaining_next = '0;
                end
                else
                begin
                    remaining_next = remaining_reg - chunk_wide;
                end
            end
        end
    end

    assign running = run_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg <= '0;
            period_reg    <= '0;
            count_reg     <= '0;
            run_reg       <= 1'b0;
        end
        else
        begin
            remaining_reg <= remaining_next;
            period_reg    <= period_next;
            count_reg     <= count_next;
            run_reg       <= run_next;
        end
    end

endmodule

>>> rtl/multi_channel_long_interval_timer_core.sv
// An input transfer goes through the input register, then the per-channel update into the
//   result register. Throughput: one item per cycle unless out_stall holds a full result;
//   every channel has its own update logic and multiplier.
// Reset: all channels stop with cleared state, cycles_per_usec = 16, max_chunk_usec = 65536,
//   both pipeline stages empty. No clearing pass; the block takes items right after reset.
module multi_channel_long_interval_timer_core #(
    parameter int NUM_CHANNELS = 5,
    parameter int PERIOD_WIDTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [mclt_pkg::MODE_W-1:0]       mode,
    input  logic [mclt_pkg::CHAN_W-1:0]       channel,
    input  logic [mclt_pkg::DUR_W-1:0]        duration_usec,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [mclt_pkg::MASK_W-1:0]       running_mask,
    output logic [mclt_pkg::MASK_W-1:0]       expired_mask,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mclt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mclt_pkg::CHUNK_W-1:0]      cfg_data
);

    logic [mclt_pkg::CYCLES_W-1:0] cycles_reg;
    logic [mclt_pkg::CHUNK_W-1:0]  chunk_reg;

    logic                          s1_valid_reg, s1_valid_next;
    mclt_pkg::mode_t               s1_mode_reg;
    logic [mclt_pkg::CHAN_W-1:0]   s1_channel_reg;
    logic [mclt_pkg::DUR_W-1:0]    s1_dur_reg;

    logic                          out_valid_reg, out_valid_next;
    logic [mclt_pkg::MASK_W-1:0]   run_mask_reg, exp_mask_reg;

    logic                          in_xfer;
    logic                          fire;
    logic                          do_tick, do_start, do_stop, do_notify;
    logic [NUM_CHANNELS-1:0]       run_vec, exp_vec;
    logic [mclt_pkg::MAX_CHANS-1:0] run_wide, exp_wide;

    // items only back up when the result register is full and held
    assign fire     = s1_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall = s1_valid_reg && out_valid_reg && out_stall;
    assign in_xfer  = in_valid && !in_stall;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycles_reg <= mclt_pkg::CYCLES_RESET;
            chunk_reg  <= mclt_pkg::CHUNK_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                mclt_pkg::CFG_CYCLES:    cycles_reg <= cfg_data[mclt_pkg::CYCLES_W-1:0];
                mclt_pkg::CFG_MAX_CHUNK: chunk_reg  <= cfg_data;
                default:                 ;
            endcase
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_xfer)
        begin
            s1_valid_next = 1'b1;
        end
        else if (fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_mode_reg    <= mclt_pkg::MODE_TICK;
            s1_channel_reg <= '0;
            s1_dur_reg     <= '0;
        end
        else if (in_xfer)
        begin
            s1_mode_reg    <= mclt_pkg::mode_t'(mode);
            s1_channel_reg <= channel;
            s1_dur_reg     <= duration_usec;
        end
    end

    always_comb
    begin
        do_tick   = 1'b0;
        do_start  = 1'b0;
        do_stop   = 1'b0;
        do_notify = 1'b0;
        unique case (s1_mode_reg)
            mclt_pkg::MODE_TICK:        do_tick  = fire;
            mclt_pkg::MODE_START:       do_start = fire;
            mclt_pkg::MODE_STOP:        do_stop  = fire;
            mclt_pkg::MODE_STOP_NOTIFY:
            begin
                do_stop   = fire;
                do_notify = fire;
            end
        endcase
    end

    // ticks reach every channel; start/stop at or above NUM_CHANNELS do nothing
    for (genvar c = 0; c < NUM_CHANNELS; c++)
    begin : g_chan
        mclt_pkg::chan_cmd_t cmd;
        logic                sel;

        assign sel        = (s1_channel_reg == mclt_pkg::CHAN_W'(c));
        assign cmd.tick   = do_tick;
        assign cmd.start  = do_start && sel;
        assign cmd.stop   = do_stop && sel;
        assign cmd.notify = do_notify && sel;

        mclt_chan #(
            .PERIOD_WIDTH (PERIOD_WIDTH)
        ) u_chan (
            .clk             (clk),
            .rst_n           (rst_n),
            .cmd             (cmd),
            .duration_usec   (s1_dur_reg),
            .cycles_per_usec (cycles_reg),
            .max_chunk_usec  (chunk_reg),
            .running         (run_vec[c]),
            .expired         (exp_vec[c])
        );
    end

    assign run_wide = mclt_pkg::MAX_CHANS'(run_vec);
    assign exp_wide = mclt_pkg::MAX_CHANS'(exp_vec);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            run_mask_reg <= run_wide[mclt_pkg::MASK_W-1:0];
            exp_mask_reg <= exp_wide[mclt_pkg::MASK_W-1:0];
        end
    end

    assign out_valid    = out_valid_reg;
    assign running_mask = run_mask_reg;
    assign expired_mask = exp_mask_reg;

endmodule

>>> rtl/mclt_checker.sv
`include "multi_channel_long_interval_timer_core_macros.svh"

module mclt_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_stall,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [mclt_pkg::MASK_W-1:0]       running_mask,
    input  logic [mclt_pkg::MASK_W-1:0]       expired_mask,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready
);

    logic                          held;
    logic [2*mclt_pkg::MASK_W-1:0] out_data;

    assign held     = out_valid && out_stall;
    assign out_data = {running_mask, expired_mask};

    // a channel that expires or is stopped with notice is never left running
    `MCLT_ASSERT_NOW(a_exp_not_run, out_valid, ~|(running_mask & expired_mask), "expired running")

    // input backpressure only comes from a held result
    `MCLT_ASSERT_NOW(a_stall_from_out, in_stall, held, "input stalled without out_stall")

    // register writes are never refused
    `MCLT_ASSERT_NOW(a_cfg_always_ready, cfg_valid, cfg_ready, "config write refused")

    `MCLT_ASSERT_NEXT(a_out_hold, held, out_valid && $stable(out_data), "stalled result changed")

endmodule

bind multi_channel_long_interval_timer_core mclt_checker u_mclt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .running_mask (running_mask),
    .expired_mask (expired_mask),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready)
);

>>> verif/mclt_result_checker.sv
`timescale 1ns / 100ps

module mclt_result_checker #(
    parameter int NUM_CHANNELS = 5,
    parameter int PERIOD_WIDTH = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic [mclt_pkg::MODE_W-1:0]     mode,
    input  logic [mclt_pkg::CHAN_W-1:0]     channel,
    input  logic [mclt_pkg::DUR_W-1:0]      duration_usec,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [mclt_pkg::MASK_W-1:0]     running_mask,
    input  logic [mclt_pkg::MASK_W-1:0]     expired_mask,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [mclt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mclt_pkg::CHUNK_W-1:0]    cfg_data,
    output int                              fail_count,
    output int                              pending
);

    typedef struct packed {
        logic [mclt_pkg::MASK_W-1:0] running;
        logic [mclt_pkg::MASK_W-1:0] expired;
    } mask_pair_t;

    mask_pair_t expected_masks[$];

    logic [mclt_pkg::CYCLES_W-1:0] cycles_per_usec;
    logic [mclt_pkg::CHUNK_W-1:0]  max_chunk;
    logic [mclt_pkg::DUR_W-1:0]    usec_left   [NUM_CHANNELS];
    logic [PERIOD_WIDTH-1:0]       period_len  [NUM_CHANNELS];
    logic [PERIOD_WIDTH-1:0]       ticks_done  [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0]       active;

    function automatic logic [PERIOD_WIDTH-1:0] usec_to_ticks(
        input logic [mclt_pkg::DUR_W-1:0] usec);
        logic [63:0] prod;
        prod = ({32'd0, usec} * {56'd0, cycles_per_usec}) >> mclt_pkg::TICK_SHIFT;
        return prod[PERIOD_WIDTH-1:0];
    endfunction

    task automatic clear_timers();
        cycles_per_usec = mclt_pkg::CYCLES_RESET;
        max_chunk       = mclt_pkg::CHUNK_RESET;
        active          = '0;
        for (int c = 0; c < NUM_CHANNELS; c++)
        begin
            usec_left[c]  = '0;
            period_len[c] = '0;
            ticks_done[c] = '0;
        end
    endtask

    // advance the timer bank by one command and return the masks it produces
    function automatic mask_pair_t timer_step(input mclt_pkg::mode_t m,
                                              input logic [mclt_pkg::CHAN_W-1:0] ch,
                                              input logic [mclt_pkg::DUR_W-1:0] dur);
        mask_pair_t res;
        logic [mclt_pkg::DUR_W-1:0] seg;
        res = '0;
        if (m == mclt_pkg::MODE_TICK)
        begin
            for (int c = 0; c < NUM_CHANNELS; c++)
            begin
                if (active[c])
                begin
                    if (ticks_done[c] != period_len[c])
                        ticks_done[c] = ticks_done[c] + 1'b1;
                    else
                    begin
                        ticks_done[c] = '0;
                        if (usec_left[c] == '0)
                        begin
                            active[c]      = 1'b0;
                            res.expired[c] = 1'b1;
                        end
                        else if (usec_left[c] < 32'(max_chunk))
                        begin
                            period_len[c] = usec_to_ticks(usec_left[c]);
                            usec_left[c]  = '0;
                        end
                        else
                            usec_left[c] = usec_left[c] - 32'(max_chunk);
                    end
                end
            end
        end
        else if (ch < NUM_CHANNELS)
        begin
            if (m == mclt_pkg::MODE_START)
            begin
                seg = (dur > 32'(max_chunk)) ? 32'(max_chunk) : dur;
                usec_left[ch]  = dur - seg;
                period_len[ch] = usec_to_ticks(seg);
                ticks_done[ch] = '0;
                active[ch]     = 1'b1;
            end
            else
            begin
                active[ch] = 1'b0;
                if (m == mclt_pkg::MODE_STOP_NOTIFY)
                    res.expired[ch] = 1'b1;
            end
        end
        for (int c = 0; c < NUM_CHANNELS; c++)
            res.running[c] = active[c];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        mask_pair_t want;
        if (!rst_n)
        begin
            clear_timers();
            expected_masks.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            // results first: an item accepted at this edge cannot have its result yet
            if (out_valid && !out_stall)
            begin
                if (expected_masks.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result transfer, got running %b expired %b",
                             $time, running_mask, expired_mask);
                end
                else
                begin
                    want = expected_masks.pop_front();
                    if (running_mask !== want.running)
                    begin
                        fail_count++;
                        $display("%0t: running_mask expected %b, got %b",
                                 $time, want.running, running_mask);
                    end
                    if (expired_mask !== want.expired)
                    begin
                        fail_count++;
                        $display("%0t: expired_mask expected %b, got %b",
                                 $time, want.expired, expired_mask);
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_masks.push_back(timer_step(mclt_pkg::mode_t'(mode), channel,
                                                    duration_usec));
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == mclt_pkg::CFG_CYCLES)
                    cycles_per_usec = cfg_data[mclt_pkg::CYCLES_W-1:0];
                else if (cfg_index == mclt_pkg::CFG_MAX_CHUNK)
                    max_chunk = cfg_data;
            end
            pending = expected_masks.size();
        end
    end

endmodule

>>> verif/tb_multi_channel_long_interval_timer_core.sv
`timescale 1ns / 100ps

module tb_multi_channel_long_interval_timer_core;

    localparam int NUM_CHANNELS = 5;
    localparam int PERIOD_WIDTH = 16;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam logic [mclt_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    logic [mclt_pkg::MODE_W-1:0]     mode;
    logic [mclt_pkg::CHAN_W-1:0]     channel;
    logic [mclt_pkg::DUR_W-1:0]      duration_usec;
    logic                            out_valid;
    logic                            out_stall;
    logic [mclt_pkg::MASK_W-1:0]     running_mask;
    logic [mclt_pkg::MASK_W-1:0]     expired_mask;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [mclt_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [mclt_pkg::CHUNK_W-1:0]    cfg_data;

    int fail_count;
    int pending;
    int cycle_count;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_cycles;
    logic [mclt_pkg::CHUNK_W-1:0] cur_chunk;

    multi_channel_long_interval_timer_core #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .PERIOD_WIDTH (PERIOD_WIDTH)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .channel       (channel),
        .duration_usec (duration_usec),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .running_mask  (running_mask),
        .expired_mask  (expired_mask),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    mclt_result_checker #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .PERIOD_WIDTH (PERIOD_WIDTH)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .channel       (channel),
        .duration_usec (duration_usec),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .running_mask  (running_mask),
        .expired_mask  (expired_mask),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // result side; a hold request is counted down here
    initial
    begin : receiver
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                out_stall <= 1'b1;
                hold_cycles--;
            end
            else
                out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    task automatic send_cmd(input mclt_pkg::mode_t m, input logic [mclt_pkg::CHAN_W-1:0] ch,
                            input logic [mclt_pkg::DUR_W-1:0] dur);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid      <= 1'b0;
            mode          <= mclt_pkg::MODE_W'($urandom);
            channel       <= mclt_pkg::CHAN_W'($urandom);
            duration_usec <= $urandom;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        mode          <= m;
        channel       <= ch;
        duration_usec <= dur;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [mclt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mclt_pkg::CHUNK_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // drains the block first; upper data bits of the cycles write are noise
    task automatic load_settings(input logic [mclt_pkg::CYCLES_W-1:0] cyc,
                                 input logic [mclt_pkg::CHUNK_W-1:0] chunk);
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        write_reg(mclt_pkg::CFG_CYCLES, {9'($urandom), cyc});
        write_reg(mclt_pkg::CFG_MAX_CHUNK, chunk);
        write_reg(CFG_SPARE, mclt_pkg::CHUNK_W'($urandom));
        cfg_valid <= 1'b0;
        cur_chunk = chunk;
    endtask

    task automatic random_cmd();
        int r;
        mclt_pkg::mode_t m;
        logic [mclt_pkg::CHAN_W-1:0] ch;
        logic [mclt_pkg::DUR_W-1:0] dur;
        r = $urandom_range(0, 99);
        if (r < 55)
            m = mclt_pkg::MODE_TICK;
        else if (r < 80)
            m = mclt_pkg::MODE_START;
        else if (r < 90)
            m = mclt_pkg::MODE_STOP;
        else
            m = mclt_pkg::MODE_STOP_NOTIFY;
        if ($urandom_range(0, 99) < 85)
            ch = mclt_pkg::CHAN_W'($urandom_range(0, NUM_CHANNELS - 1));
        else
            ch = mclt_pkg::CHAN_W'($urandom_range(NUM_CHANNELS, 7));
        r = $urandom_range(0, 99);
        if (r < 40)
            dur = $urandom_range(0, 31);
        else if (r < 65)
            dur = $urandom_range(0, 511);
        else if (r < 80)
            dur = $urandom;
        else if (r < 90)
            dur = 32'(cur_chunk) + $urandom_range(0, 2) - 1;  // segment boundary
        else
            dur = 32'hFFFF_FFFF - $urandom_range(0, 3);
        send_cmd(m, ch, dur);
    endtask

    task automatic run_phase(input logic [mclt_pkg::CYCLES_W-1:0] cyc,
                             input logic [mclt_pkg::CHUNK_W-1:0] chunk,
                             input int idle_pct, input int stall_pct, input int hold,
                             input int n);
        load_settings(cyc, chunk);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        hold_cycles    = hold;
        repeat (n)
            random_cmd();
    endtask

    initial
    begin : stimulus
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        mode           = mclt_pkg::MODE_TICK;
        channel        = '0;
        duration_usec  = '0;
        cfg_valid      = 1'b0;
        cfg_index      = mclt_pkg::CFG_CYCLES;
        cfg_data       = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        cur_chunk      = mclt_pkg::CHUNK_RESET;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: expiry, idle channels, out of range, restart, stops
        send_cmd(mclt_pkg::MODE_TICK, 3'd0, 32'd0);
        send_cmd(mclt_pkg::MODE_START, 3'd0, 32'd0);
        send_cmd(mclt_pkg::MODE_START, 3'd1, 32'd32);
        send_cmd(mclt_pkg::MODE_START, 3'd2, 32'hFFFF_FFFF);
        send_cmd(mclt_pkg::MODE_START, 3'd4, 32'd100000);
        send_cmd(mclt_pkg::MODE_START, 3'd7, 32'd5);
        send_cmd(mclt_pkg::MODE_STOP, 3'd5, 32'd0);
        send_cmd(mclt_pkg::MODE_STOP_NOTIFY, 3'd6, 32'd0);
        send_cmd(mclt_pkg::MODE_STOP_NOTIFY, 3'd3, 32'd0);
        send_cmd(mclt_pkg::MODE_TICK, 3'd7, 32'd0);
        send_cmd(mclt_pkg::MODE_TICK, 3'd0, 32'd0);
        send_cmd(mclt_pkg::MODE_TICK, 3'd0, 32'd0);
        send_cmd(mclt_pkg::MODE_START, 3'd0, 32'd16);
        send_cmd(mclt_pkg::MODE_START, 3'd0, 32'd48);
        send_cmd(mclt_pkg::MODE_STOP, 3'd2, 32'd0);
        send_cmd(mclt_pkg::MODE_STOP_NOTIFY, 3'd1, 32'd0);
        send_cmd(mclt_pkg::MODE_TICK, 3'd0, 32'd0);

        // zero cycles and zero segment limit
        load_settings(8'd0, 17'd0);
        send_cmd(mclt_pkg::MODE_START, 3'd0, 32'd5);
        send_cmd(mclt_pkg::MODE_START, 3'd1, 32'd0);
        send_cmd(mclt_pkg::MODE_TICK, 3'd0, 32'd0);
        send_cmd(mclt_pkg::MODE_TICK, 3'd0, 32'd0);
        send_cmd(mclt_pkg::MODE_STOP_NOTIFY, 3'd0, 32'd0);

        // period wider than the counter gets truncated
        load_settings(8'd255, 17'h1FFFF);
        send_cmd(mclt_pkg::MODE_START, 3'd2, 32'h0001_FFFF);
        send_cmd(mclt_pkg::MODE_START, 3'd3, 32'd200000);
        send_cmd(mclt_pkg::MODE_TICK, 3'd0, 32'd0);

        run_phase(8'd16, 17'd16, 0, 0, 0, 95);
        run_phase(8'd255, 17'd1, 78, 0, 0, 95);
        run_phase(8'd1, mclt_pkg::CHUNK_RESET, 0, 78, 0, 95);
        run_phase(mclt_pkg::CYCLES_W'($urandom_range(1, 255)),
                  mclt_pkg::CHUNK_W'($urandom_range(1, 64)), 20, 20, 0, 95);
        run_phase(8'd0, 17'd0, 0, 0, 300, 95);
        run_phase(mclt_pkg::CYCLES_W'($urandom_range(1, 255)), 17'h1FFFF, 20, 20, 0, 95);
        run_phase(8'd128, 17'd3, 0, 0, 0, 95);

        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
